@@ design/cfr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfr_pkg: shared definitions for the command frame receiver
// Frame layout constants, command type codes, status codes and the
// float helpers used when a command value is applied.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // Frame layout
  localparam logic [7:0]  START_MARK = 8'hB5;
  localparam int          HeadBytes  = 6;
  localparam int          CountW     = 3;

  // Command type codes
  localparam logic [7:0] CMD_PWM   = 8'h01;
  localparam logic [7:0] CMD_SPEED = 8'h02;
  localparam logic [7:0] CMD_GAINP = 8'h03;
  localparam logic [7:0] CMD_GAINI = 8'h04;
  localparam logic [7:0] CMD_GAIND = 8'h05;
  localparam logic [7:0] CMD_MODE  = 8'h06;
  localparam logic [7:0] CMD_RUN   = 8'h07;

  // Frame status codes
  typedef enum logic [1:0] {
    STAT_APPLIED  = 2'd0,
    STAT_BAD_SUM  = 2'd1,
    STAT_BAD_TYPE = 2'd2
  } status_t;

  // IEEE single constants
  localparam logic [31:0] BITS_HALF = 32'h3F00_0000;
  localparam logic [31:0] BITS_ONE  = 32'h3F80_0000;
  localparam logic [7:0]  EXP_MAX   = 8'hFF;
  localparam logic [7:0]  EXP_ONE   = 8'd127;
  localparam logic [7:0]  EXP_SAT   = 8'd135;
  localparam logic [7:0]  EXP_TOP   = 8'd134;

  // Truncate a single toward zero and saturate to 0..255; NaN and negatives give 0
  function automatic logic [7:0] level_from_bits(input logic [31:0] w);
    logic [7:0]  ex;
    logic [22:0] man;
    logic [2:0]  sh;
    logic [7:0]  lvl;
    ex  = w[30:23];
    man = w[22:0];
    sh  = 3'(EXP_TOP - ex);
    if (ex == EXP_MAX) begin
      lvl = (man != 23'd0 || w[31]) ? 8'd0 : 8'hFF;
    end else if (w[31] || ex < EXP_ONE) begin
      lvl = 8'd0;
    end else if (ex >= EXP_SAT) begin
      lvl = 8'hFF;
    end else begin
      lvl = {1'b1, man[22:16]} >> sh;
    end
    return lvl;
  endfunction

  // Strictly below 0.5; NaN compares false
  function automatic logic below_half(input logic [31:0] w);
    logic res;
    if (w[30:23] == EXP_MAX && w[22:0] != 23'd0) begin
      res = 1'b0;
    end else if (w[31]) begin
      res = 1'b1;
    end else begin
      res = (w < BITS_HALF);
    end
    return res;
  endfunction

endpackage

@@ design/command_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// command_frame_receiver: serial command frame parser with XOR checksum
// Collects 7-byte frames (start, type, little-endian float, checksum) and
// applies the command, giving one result item per finished frame.
// ----------------------------------------------------------------------------
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------------
//  input   | rx_valid  | rx_stall  | rx_byte
//  result  | res_valid | res_stall | frame_status .. motor_on (9 fields)
//
//  One byte is taken per cycle while the input is not stalled; a byte
//  waits in the input register and is parsed there, and the result
//  register loads as the frame's last byte is parsed out of it.
//  Rate is set by the single parse stage between input and result register.
//  Reset clears frame state and all settings; no result is pending after it.
//  A stalled result holds only a frame's last byte in the input register,
//  which then stalls the input; other bytes pass a stalled result.
//
module command_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  frame_status,
  output logic [7:0]  command_type,
  output logic [7:0]  pwm_level,
  output logic [31:0] speed_target,
  output logic [31:0] gain_p,
  output logic [31:0] gain_i,
  output logic [31:0] gain_d,
  output logic        automatic_mode,
  output logic        motor_on
);

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // Frame state
  logic                      in_frame, in_frame_next;
  logic [cfr_pkg::CountW-1:0] byte_count, byte_count_next;
  logic [7:0]                type_byte;
  logic [31:0]               value_word;
  logic [7:0]                running_xor, running_xor_next;

  // Settings
  logic [7:0]  drive_level, drive_level_next;
  logic [7:0]  saved_level, saved_level_next;
  logic [31:0] setpoint_word, setpoint_word_next;
  logic [31:0] p_word, p_word_next;
  logic [31:0] i_word, i_word_next;
  logic [31:0] d_word, d_word_next;
  logic        auto_flag, auto_flag_next;
  logic        enabled_flag, enabled_flag_next;

  logic                 advance;
  logic                 frame_end;
  logic                 finish;
  cfr_pkg::status_t     status_next;

  // Parse stage moves unless a frame's last byte meets a stalled result
  assign frame_end = in_frame &&
                     (byte_count >= cfr_pkg::CountW'(cfr_pkg::HeadBytes));
  assign advance   = s1_valid && (!frame_end || !res_valid || !res_stall);
  assign rx_stall  = s1_valid && !advance;
  assign finish    = advance && frame_end;

  // Capture input byte
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!rx_stall) begin
      s1_valid <= rx_valid;
    end
    if (!rx_stall && rx_valid) begin
      s1_byte <= rx_byte;
    end
  end

  // Frame tracking: hunt for start, count bytes, fold checksum
  always_comb begin
    in_frame_next    = in_frame;
    byte_count_next  = byte_count;
    running_xor_next = running_xor;
    if (!in_frame) begin
      if (s1_byte == cfr_pkg::START_MARK) begin
        in_frame_next    = 1'b1;
        byte_count_next  = cfr_pkg::CountW'(1);
        running_xor_next = s1_byte;
      end
    end else if (byte_count < cfr_pkg::CountW'(cfr_pkg::HeadBytes)) begin
      byte_count_next  = byte_count + cfr_pkg::CountW'(1);
      running_xor_next = running_xor ^ s1_byte;
    end else begin
      in_frame_next   = 1'b0;
      byte_count_next = '0;
    end
  end

  // Apply the command of a finished frame
  always_comb begin
    drive_level_next   = drive_level;
    saved_level_next   = saved_level;
    setpoint_word_next = setpoint_word;
    p_word_next        = p_word;
    i_word_next        = i_word;
    d_word_next        = d_word;
    auto_flag_next     = auto_flag;
    enabled_flag_next  = enabled_flag;
    status_next        = cfr_pkg::STAT_APPLIED;
    if (running_xor != s1_byte) begin
      status_next = cfr_pkg::STAT_BAD_SUM;
    end else begin
      case (type_byte)
        cfr_pkg::CMD_PWM:   drive_level_next   = cfr_pkg::level_from_bits(value_word);
        cfr_pkg::CMD_SPEED: setpoint_word_next = value_word;
        cfr_pkg::CMD_GAINP: p_word_next        = value_word;
        cfr_pkg::CMD_GAINI: i_word_next        = value_word;
        cfr_pkg::CMD_GAIND: d_word_next        = value_word;
        cfr_pkg::CMD_MODE:  auto_flag_next     = !cfr_pkg::below_half(value_word);
        cfr_pkg::CMD_RUN: begin
          if (value_word == cfr_pkg::BITS_ONE && !enabled_flag) begin
            enabled_flag_next = 1'b1;
            if (!auto_flag) begin
              drive_level_next = saved_level;
            end
          end else if (value_word[30:0] == 31'd0 && enabled_flag) begin
            enabled_flag_next = 1'b0;
            saved_level_next  = drive_level;
            drive_level_next  = 8'd0;
          end
        end
        default: status_next = cfr_pkg::STAT_BAD_TYPE;
      endcase
    end
  end

  // Update frame state and capture type and value bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      byte_count  <= '0;
      running_xor <= 8'd0;
    end else if (advance) begin
      in_frame    <= in_frame_next;
      byte_count  <= byte_count_next;
      running_xor <= running_xor_next;
    end
    if (advance && in_frame) begin
      case (byte_count)
        3'd1:    type_byte          <= s1_byte;
        3'd2:    value_word[7:0]    <= s1_byte;
        3'd3:    value_word[15:8]   <= s1_byte;
        3'd4:    value_word[23:16]  <= s1_byte;
        3'd5:    value_word[31:24]  <= s1_byte;
        default: ;
      endcase
    end
  end

  // Commit settings at the end of a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_level   <= 8'd0;
      saved_level   <= 8'd0;
      setpoint_word <= 32'd0;
      p_word        <= 32'd0;
      i_word        <= 32'd0;
      d_word        <= 32'd0;
      auto_flag     <= 1'b0;
      enabled_flag  <= 1'b0;
    end else if (finish) begin
      drive_level   <= drive_level_next;
      saved_level   <= saved_level_next;
      setpoint_word <= setpoint_word_next;
      p_word        <= p_word_next;
      i_word        <= i_word_next;
      d_word        <= d_word_next;
      auto_flag     <= auto_flag_next;
      enabled_flag  <= enabled_flag_next;
    end
  end

  // Result register: load on frame end, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (finish) begin
      frame_status   <= status_next;
      command_type   <= type_byte;
      pwm_level      <= drive_level_next;
      speed_target   <= setpoint_word_next;
      gain_p         <= p_word_next;
      gain_i         <= i_word_next;
      gain_d         <= d_word_next;
      automatic_mode <= auto_flag_next;
      motor_on       <= enabled_flag_next;
    end
  end

`ifndef SYNTHESIS
  // Idle hunting always has a cleared byte count
  assert property (@(posedge clk) disable iff (rst) !in_frame |-> byte_count == '0)
    else $error("byte count not cleared while idle");

  // Count never runs past the checksum position
  assert property (@(posedge clk) disable iff (rst)
    byte_count <= cfr_pkg::CountW'(cfr_pkg::HeadBytes))
    else $error("byte count out of range");

  // A finished frame returns to idle hunting
  assert property (@(posedge clk) disable iff (rst) finish |=> !in_frame)
    else $error("frame did not close");

  // Only defined status codes are reported
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (frame_status == cfr_pkg::STAT_APPLIED ||
                   frame_status == cfr_pkg::STAT_BAD_SUM ||
                   frame_status == cfr_pkg::STAT_BAD_TYPE))
    else $error("undefined frame status");

  // Motor off after a stop means zero drive level unless a pwm command followed
  assert property (@(posedge clk) disable iff (rst)
    finish && enabled_flag && !enabled_flag_next |-> drive_level_next == 8'd0)
    else $error("stop left drive level nonzero");
`endif

endmodule

@@ sim/frame_result_checker.sv @@
// ----------------------------------------------------------------------------
// frame_result_checker: frame parser predictor and result comparator
// Watches the byte channel and the result channel of the command frame
// receiver. Rebuilds frame assembly, checksum and command effects in its
// own state, queues one expected result per finished frame and compares
// every accepted result field by field against the oldest one.
// ----------------------------------------------------------------------------
module frame_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  input  logic        rx_stall,
  input  logic [7:0]  rx_byte,
  input  logic        res_valid,
  input  logic        res_stall,
  input  logic [1:0]  frame_status,
  input  logic [7:0]  command_type,
  input  logic [7:0]  pwm_level,
  input  logic [31:0] speed_target,
  input  logic [31:0] gain_p,
  input  logic [31:0] gain_i,
  input  logic [31:0] gain_d,
  input  logic        automatic_mode,
  input  logic        motor_on,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    cfr_pkg::status_t status;
    logic [7:0]  ctype;
    logic [7:0]  pwm;
    logic [31:0] speed;
    logic [31:0] kp;
    logic [31:0] ki;
    logic [31:0] kd;
    logic        auto_m;
    logic        motor;
  } frame_result_t;

  frame_result_t frame_results_q[$];

  // Parser and settings copy
  logic        in_frame;
  logic [2:0]  byte_idx;
  logic [7:0]  head [0:5];
  logic [7:0]  xor_acc;
  logic [7:0]  drive_lvl;
  logic [7:0]  saved_lvl;
  logic [31:0] setpoint;
  logic [31:0] kp_bits;
  logic [31:0] ki_bits;
  logic [31:0] kd_bits;
  logic        auto_mode;
  logic        motor_en;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Convert float bits to a drive level: truncate, clamp to 0..255, NaN to 0
  function automatic logic [7:0] pwm_from_float(input logic [31:0] w);
    logic [7:0]  ex;
    logic [23:0] mant;
    logic [23:0] mag;
    ex   = w[30:23];
    mant = {1'b1, w[22:0]};
    if (ex == 8'hFF) begin
      return (w[22:0] != 23'd0 || w[31]) ? 8'd0 : 8'd255;
    end
    if (w[31] || ex < 8'd127) begin
      return 8'd0;
    end
    if (ex >= 8'd135) begin
      return 8'd255;
    end
    mag = mant >> (8'd150 - ex);
    return (mag > 24'd255) ? 8'd255 : mag[7:0];
  endfunction

  // Float strictly less than one half; NaN is never less
  function automatic logic under_half(input logic [31:0] w);
    if (w[30:23] == 8'hFF && w[22:0] != 23'd0) begin
      return 1'b0;
    end
    if (w[31]) begin
      return 1'b1;
    end
    return w < 32'h3F00_0000;
  endfunction

  // Advance the frame parser by one byte; queue a result when a frame ends
  task automatic parse_byte(input logic [7:0] b);
    logic [7:0]    ctype;
    logic [31:0]   val;
    frame_result_t r;
    if (!in_frame) begin
      if (b == cfr_pkg::START_MARK) begin
        in_frame = 1'b1;
        head[0]  = b;
        xor_acc  = b;
        byte_idx = 3'd1;
      end
      return;
    end
    if (byte_idx < 3'd6) begin
      head[byte_idx] = b;
      xor_acc        = xor_acc ^ b;
      byte_idx       = byte_idx + 3'd1;
      return;
    end
    in_frame = 1'b0;
    byte_idx = 3'd0;
    ctype    = head[1];
    val      = {head[5], head[4], head[3], head[2]};
    r.status = cfr_pkg::STAT_APPLIED;
    if (xor_acc != b) begin
      r.status = cfr_pkg::STAT_BAD_SUM;
    end else begin
      case (ctype)
        cfr_pkg::CMD_PWM:   drive_lvl = pwm_from_float(val);
        cfr_pkg::CMD_SPEED: setpoint  = val;
        cfr_pkg::CMD_GAINP: kp_bits   = val;
        cfr_pkg::CMD_GAINI: ki_bits   = val;
        cfr_pkg::CMD_GAIND: kd_bits   = val;
        cfr_pkg::CMD_MODE:  auto_mode = !under_half(val);
        cfr_pkg::CMD_RUN: begin
          // start only from stopped; stop only on a signed zero while running
          if (val == cfr_pkg::BITS_ONE && !motor_en) begin
            motor_en = 1'b1;
            if (!auto_mode) begin
              drive_lvl = saved_lvl;
            end
          end else if (val[30:0] == 31'd0 && motor_en) begin
            motor_en  = 1'b0;
            saved_lvl = drive_lvl;
            drive_lvl = 8'd0;
          end
        end
        default: r.status = cfr_pkg::STAT_BAD_TYPE;
      endcase
    end
    r.ctype  = ctype;
    r.pwm    = drive_lvl;
    r.speed  = setpoint;
    r.kp     = kp_bits;
    r.ki     = ki_bits;
    r.kd     = kd_bits;
    r.auto_m = auto_mode;
    r.motor  = motor_en;
    frame_results_q.push_back(r);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Compare one accepted result with the oldest expectation
  task automatic check_result();
    frame_result_t r;
    if (frame_results_q.size() == 0) begin
      $display("%0t ns: unexpected result, expected none, actual status %0d type %0h",
               $time, frame_status, command_type);
      fail_count++;
      return;
    end
    r = frame_results_q.pop_front();
    check_field("frame_status", 32'(r.status), 32'(frame_status));
    check_field("command_type", 32'(r.ctype), 32'(command_type));
    check_field("pwm_level", 32'(r.pwm), 32'(pwm_level));
    check_field("speed_target", r.speed, speed_target);
    check_field("gain_p", r.kp, gain_p);
    check_field("gain_i", r.ki, gain_i);
    check_field("gain_d", r.kd, gain_d);
    check_field("automatic_mode", 32'(r.auto_m), 32'(automatic_mode));
    check_field("motor_on", 32'(r.motor), 32'(motor_on));
  endtask

  // Track both channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      in_frame  = 1'b0;
      byte_idx  = 3'd0;
      xor_acc   = 8'd0;
      drive_lvl = 8'd0;
      saved_lvl = 8'd0;
      setpoint  = 32'd0;
      kp_bits   = 32'd0;
      ki_bits   = 32'd0;
      kd_bits   = 32'd0;
      auto_mode = 1'b0;
      motor_en  = 1'b0;
      frame_results_q.delete();
    end else begin
      if (res_valid && !res_stall) begin
        check_result();
      end
      if (rx_valid && !rx_stall) begin
        parse_byte(rx_byte);
      end
    end
    pending <= frame_results_q.size();
  end

endmodule

@@ sim/command_frame_receiver_tb.sv @@
// ----------------------------------------------------------------------------
// command_frame_receiver_tb: byte stream stimulus and verdict
// Feeds noise bytes, well-formed command frames with random and corner
// float values, bad checksums and unknown types into the receiver, with
// random sender gaps and result back-pressure; a checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module command_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        rx_valid;
  logic        rx_stall;
  logic [7:0]  rx_byte;
  logic        res_valid;
  logic        res_stall;
  logic [1:0]  frame_status;
  logic [7:0]  command_type;
  logic [7:0]  pwm_level;
  logic [31:0] speed_target;
  logic [31:0] gain_p;
  logic [31:0] gain_i;
  logic [31:0] gain_d;
  logic        automatic_mode;
  logic        motor_on;
  int          fail_count;
  int          pending;

  int send_idle_pct = 14;
  int recv_idle_pct = 76;
  int frame_items   = 0;

  command_frame_receiver dut (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (rx_valid),
    .rx_stall       (rx_stall),
    .rx_byte        (rx_byte),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .frame_status   (frame_status),
    .command_type   (command_type),
    .pwm_level      (pwm_level),
    .speed_target   (speed_target),
    .gain_p         (gain_p),
    .gain_i         (gain_i),
    .gain_d         (gain_d),
    .automatic_mode (automatic_mode),
    .motor_on       (motor_on)
  );

  frame_result_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (rx_valid),
    .rx_stall       (rx_stall),
    .rx_byte        (rx_byte),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .frame_status   (frame_status),
    .command_type   (command_type),
    .pwm_level      (pwm_level),
    .speed_target   (speed_target),
    .gain_p         (gain_p),
    .gain_i         (gain_i),
    .gain_d         (gain_d),
    .automatic_mode (automatic_mode),
    .motor_on       (motor_on),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one byte after a random gap and hold it until accepted
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
  endtask

  // Send start, type, value and checksum; corrupt flips checksum bits
  task automatic send_frame(input logic [7:0] ctype, input logic [31:0] val,
                            input bit corrupt);
    logic [7:0] fb [0:6];
    fb[0] = cfr_pkg::START_MARK;
    fb[1] = ctype;
    fb[2] = val[7:0];
    fb[3] = val[15:8];
    fb[4] = val[23:16];
    fb[5] = val[31:24];
    fb[6] = fb[0] ^ fb[1] ^ fb[2] ^ fb[3] ^ fb[4] ^ fb[5];
    if (corrupt) begin
      fb[6] = fb[6] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < 7; i++) begin
      push_byte(fb[i]);
    end
    frame_items += 7;
  endtask

  // Pick a float value, weighted toward conversion and compare corners
  function automatic logic [31:0] pick_value();
    case ($urandom_range(11))
      0:       return 32'h7F80_0000;
      1:       return 32'hFF80_0000;
      2:       return {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};
      3:       return 32'h0000_0000;
      4:       return 32'h8000_0000;
      5:       return cfr_pkg::BITS_ONE;
      6:       return cfr_pkg::BITS_HALF;
      7:       return cfr_pkg::BITS_HALF - 32'd1;
      8:       return {1'($urandom), 8'(127 + $urandom_range(8)), 23'($urandom)};
      9:       return {1'($urandom), 8'($urandom_range(126)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [7:0]  ctype;
    logic [31:0] val;
    int          roll;
    rst      <= 1'b1;
    rx_valid <= 1'b0;
    rx_byte  <= 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle noise at both byte extremes, start byte inside a
    // frame value, unknown type zero, checksum mismatch
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h5A);
    send_frame(cfr_pkg::CMD_PWM, 32'h437F_00B5, 1'b0);
    send_frame(8'h00, 32'hFFFF_FFFF, 1'b0);
    send_frame(cfr_pkg::CMD_SPEED, 32'h1234_5678, 1'b1);

    // Random frames with some noise, idling pattern changing by phase
    while (frame_items < 550) begin
      if (frame_items < 190) begin
        send_idle_pct = 14;
        recv_idle_pct = 76;
      end else if (frame_items < 370) begin
        send_idle_pct = 76;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      roll = $urandom_range(99);
      if (roll < 12) begin
        push_byte(8'($urandom));
      end else begin
        if ($urandom_range(99) < 88) begin
          ctype = 8'($urandom_range(1, 7));
        end else if ($urandom_range(1) == 0) begin
          ctype = 8'h00;
        end else begin
          ctype = 8'($urandom_range(8, 255));
        end
        roll = $urandom_range(99);
        if (ctype == cfr_pkg::CMD_RUN && roll < 45) begin
          val = cfr_pkg::BITS_ONE;
        end else if (ctype == cfr_pkg::CMD_RUN && roll < 80) begin
          val = {1'($urandom), 31'd0};
        end else begin
          val = pick_value();
        end
        send_frame(ctype, val, $urandom_range(99) < 8);
      end
    end
    rx_valid <= 1'b0;

    // Drain outstanding results, then let the pipeline settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
